// ===== rtl/dhp_pkg.sv =====
`default_nettype none

package dhp_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_INDEX_BITS = 1;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_MODULUS = 1'd0;
  localparam cfg_index_t REG_GENERATOR = 1'd1;

  localparam logic KIND_PUBLIC = 1'b0;
  localparam logic KIND_SECRET = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/dhp_if.sv =====
`default_nettype none

interface dhp_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface dhp_out_if;
  logic valid;
  logic ready;
  logic [31:0] result_value;
  logic result_kind;
  logic key_missing;

  modport source (output valid, output result_value, output result_kind,
                  output key_missing, input ready);
  modport sink (input valid, input result_value, input result_kind,
                input key_missing, output ready);
endinterface

`default_nettype wire

// ===== rtl/dhp_modmul.sv =====
`default_nettype none

module dhp_modmul
  import dhp_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic [W-1:0]      product,
  output logic              done
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] a_sh;
  logic [W-1:0] b_q;
  logic [W-1:0] m_q;
  logic [W-1:0] acc;
  logic [CW-1:0] cnt;
  logic busy;

  logic [W+1:0] t;
  logic [W+1:0] m1;
  logic [W+1:0] m2;
  logic [W+1:0] d1;
  logic [W+1:0] d2;
  logic [W-1:0] acc_next;

  // One multiplier bit per cycle, most significant first. The running sum
  // stays below m, so 2*acc + b is below 3m and at most two subtractions
  // of m bring it back into range.
  always_comb begin
    t  = {1'b0, acc, 1'b0} + (a_sh[W-1] ? {2'b00, b_q} : '0);
    m1 = {2'b00, m_q};
    m2 = {1'b0, m_q, 1'b0};
    d1 = t - m1;
    d2 = t - m2;
    if (t >= m2) begin
      acc_next = d2[W-1:0];
    end else if (t >= m1) begin
      acc_next = d1[W-1:0];
    end else begin
      acc_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      a_sh <= a;
      b_q  <= b;
      m_q  <= m;
      acc  <= '0;
      done <= 1'b0;
    end else if (busy) begin
      acc  <= acc_next;
      a_sh <= {a_sh[W-2:0], 1'b0};
      cnt  <= cnt - CW'(1);
      done <= (cnt == CW'(1));
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

// ===== rtl/diffie_hellman_party.sv =====
// Channel | Dir | Payload                                 | Accepted when
// req     | in  | kind, value                             | req.valid && req.ready
// rsp     | out | result_value, result_kind, key_missing  | rsp.valid && rsp.ready
// cfg     | in  | cfg_index, cfg_data                     | cfg_we
//
// One item is worked on at a time. A modular product runs bit-serially in the
// multiplier, most significant multiplier bit first.
// An item takes one reduction product, then per exponent bit one square and one
// more product when the bit is set, unless the key is missing or the modulus is 0.
// Reset is synchronous; it clears the loaded key and restores 23 and 5.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module diffie_hellman_party
  import dhp_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  dhp_in_if.sink                         req,
  dhp_out_if.source                      rsp
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BIT,
    S_MULT,
    S_SQUARE,
    S_DONE
  } state_t;

  state_t state;

  logic [W-1:0] modulus;
  logic [W-1:0] generator;
  logic [W-1:0] priv_exp;
  logic key_loaded;
  logic [W-1:0] base;
  logic [W-1:0] ex;
  logic [W-1:0] acc;
  logic [W-1:0] bb;
  logic [CW-1:0] bit_cnt;
  logic res_kind;
  logic res_missing;
  logic mm_start;
  logic mm_done;
  logic [W-1:0] mm_a;
  logic [W-1:0] mm_b;
  logic [W-1:0] mm_product;
  logic out_valid;
  logic [W-1:0] out_value;
  logic out_kind;
  logic out_missing;

  always_comb begin
    case (state)
      S_REDUCE: begin
        mm_a = base;
        mm_b = acc;
      end
      S_MULT: begin
        mm_a = acc;
        mm_b = bb;
      end
      default: begin
        mm_a = bb;
        mm_b = bb;
      end
    endcase
  end

  dhp_modmul #(
    .W(W)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .m      (modulus),
    .product(mm_product),
    .done   (mm_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= W'(23);
      generator  <= W'(5);
      priv_exp   <= '0;
      key_loaded <= 1'b0;
      state      <= S_IDLE;
      mm_start   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:   modulus <= cfg_data[W-1:0];
          REG_GENERATOR: generator <= cfg_data[W-1:0];
          default: ;
        endcase
      end
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_kind <= req.kind;
            bit_cnt  <= CW'(W);
            if (req.kind == KIND_SECRET && !key_loaded) begin
              res_missing <= 1'b1;
              acc         <= '0;
              mm_start    <= 1'b0;
              state       <= S_DONE;
            end else begin
              res_missing <= 1'b0;
              acc         <= (modulus > W'(1)) ? W'(1) : '0;
              if (req.kind == KIND_PUBLIC) begin
                priv_exp   <= req.value[W-1:0];
                key_loaded <= 1'b1;
                ex         <= req.value[W-1:0];
                base       <= generator;
              end else begin
                ex   <= priv_exp;
                base <= req.value[W-1:0];
              end
              if (modulus == '0) begin
                mm_start <= 1'b0;
                state    <= S_DONE;
              end else begin
                mm_start <= 1'b1;
                state    <= S_REDUCE;
              end
            end
          end else begin
            mm_start <= 1'b0;
          end
        end
        S_REDUCE: begin
          mm_start <= 1'b0;
          if (mm_done) begin
            bb    <= mm_product;
            state <= S_BIT;
          end
        end
        S_BIT: begin
          mm_start <= (bit_cnt != '0);
          if (bit_cnt == '0) begin
            state <= S_DONE;
          end else if (ex[0]) begin
            state <= S_MULT;
          end else begin
            state <= S_SQUARE;
          end
        end
        S_MULT: begin
          mm_start <= mm_done;
          if (mm_done) begin
            acc   <= mm_product;
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          mm_start <= 1'b0;
          if (mm_done) begin
            bb      <= mm_product;
            ex      <= {1'b0, ex[W-1:1]};
            bit_cnt <= bit_cnt - CW'(1);
            state   <= S_BIT;
          end
        end
        S_DONE: begin
          mm_start <= 1'b0;
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_value   <= acc;
            out_kind    <= res_kind;
            out_missing <= res_missing;
            state       <= S_IDLE;
          end
        end
        default: begin
          mm_start <= 1'b0;
          state    <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE) && !rst;
  assign rsp.valid        = out_valid;
  assign rsp.result_value = FIELD_BITS'(out_value);
  assign rsp.result_kind  = out_kind;
  assign rsp.key_missing  = out_missing;

endmodule

`default_nettype wire

// ===== rtl/dhp_checker.sv =====
`default_nettype none

module dhp_checker
  import dhp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  req_valid,
  input wire logic                  req_ready,
  input wire logic                  rsp_valid,
  input wire logic                  rsp_ready,
  input wire logic [FIELD_BITS-1:0] rsp_result_value,
  input wire logic                  rsp_result_kind,
  input wire logic                  rsp_key_missing
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item dropped before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while one is in work");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_key_missing |-> rsp_result_value == '0 &&
      rsp_result_kind == KIND_SECRET)
    else $error("missing-key result is not a zero secret");

  a_public_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_result_kind == KIND_PUBLIC |-> !rsp_key_missing)
    else $error("public key result flagged as missing key");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared while the block was idle");

endmodule

bind diffie_hellman_party dhp_checker u_dhp_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_result_value(rsp.result_value),
  .rsp_result_kind (rsp.result_kind),
  .rsp_key_missing (rsp.key_missing)
);

`default_nettype wire

// ===== bench/tb_diffie_hellman_party.sv =====
`timescale 1ns / 100ps

module tb_diffie_hellman_party;
  import dhp_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
  } dh_request_t;

  typedef struct packed {
    logic [31:0] value;
    logic        kind;
    logic        missing;
  } dh_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MODULUS;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  dhp_in_if req_if ();
  dhp_out_if rsp_if ();

  diffie_hellman_party dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_if),
    .rsp(rsp_if)
  );

  dh_request_t pending_requests[$];
  dh_answer_t expected_answers[$];

  logic [31:0] modulus_copy = 32'd23;
  logic [31:0] generator_copy = 32'd5;
  logic [31:0] held_key = '0;
  logic key_present = 1'b0;

  bit calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned accept_hold = 0;
  int unsigned errors = 0;
  int unsigned n_public = 0;
  int unsigned n_secret = 0;
  int unsigned n_missing = 0;
  int unsigned n_writes = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [31:0] modexp(logic [31:0] base, logic [31:0] expo,
                                         logic [31:0] m);
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] mm;
    int i;
    if (m == 32'd0) return 32'd0;
    mm = {32'd0, m};
    acc = 64'd1 % mm;
    b = {32'd0, base} % mm;
    for (i = 0; i < 32; i++) begin
      if (expo[i]) acc = (acc * b) % mm;
      b = (b * b) % mm;
    end
    return acc[31:0];
  endfunction

  function automatic void record_request(logic kind, logic [31:0] value);
    dh_answer_t ans;
    ans.kind = kind;
    ans.missing = 1'b0;
    ans.value = '0;
    if (kind == KIND_PUBLIC) begin
      held_key = value;
      key_present = 1'b1;
      ans.value = modexp(generator_copy, held_key, modulus_copy);
      n_public++;
    end else if (key_present) begin
      ans.value = modexp(value, held_key, modulus_copy);
      n_secret++;
    end else begin
      ans.missing = 1'b1;
      n_secret++;
      n_missing++;
    end
    expected_answers.push_back(ans);
  endfunction

  function automatic int unsigned pick_gap(bit receiver);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 60);
    return receiver ? $urandom_range(500, 3000) : $urandom_range(100, 300);
  endfunction

  function automatic void queue_request(logic kind, logic [31:0] value);
    dh_request_t item;
    item.kind = kind;
    item.value = value;
    pending_requests.push_back(item);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 64);
      3: return modulus_copy - 32'd1;
      4: return modulus_copy + $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODULUS) modulus_copy = data;
    else generator_copy = data;
    n_writes++;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_if.valid || expected_answers.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // Request side: present queued items with random gaps and predict each accepted one.
  always @(posedge clk) begin
    dh_request_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.kind <= KIND_PUBLIC;
      req_if.value <= '0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) record_request(req_if.kind, req_if.value);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap == 0 && pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          req_if.valid <= 1'b1;
          req_if.kind <= nxt.kind;
          req_if.value <= nxt.value;
          if ($urandom_range(0, 15) == 0) calm = !calm;
          send_gap = pick_gap(1'b0);
        end else begin
          if (send_gap != 0) send_gap--;
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each accepted item against the oldest prediction.
  always @(posedge clk) begin
    dh_answer_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      accept_hold = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected item value=%h kind=%b key_missing=%b", $time,
                   rsp_if.result_value, rsp_if.result_kind, rsp_if.key_missing);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (rsp_if.result_value !== want.value) begin
            $display("%0t: result_value expected %h actual %h", $time, want.value,
                     rsp_if.result_value);
            errors++;
          end
          if (rsp_if.result_kind !== want.kind) begin
            $display("%0t: result_kind expected %b actual %b", $time, want.kind,
                     rsp_if.result_kind);
            errors++;
          end
          if (rsp_if.key_missing !== want.missing) begin
            $display("%0t: key_missing expected %b actual %b", $time, want.missing,
                     rsp_if.key_missing);
            errors++;
          end
        end
        accept_hold = pick_gap(1'b1);
      end
      if (accept_hold != 0) begin
        accept_hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned count;
    int unsigned burst;
    logic [31:0] m;
    logic [31:0] g;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Shared secrets asked before any key, then keys and peers at the edges.
    queue_request(KIND_SECRET, 32'd0);
    queue_request(KIND_SECRET, 32'hFFFF_FFFF);
    queue_request(KIND_PUBLIC, 32'd0);
    queue_request(KIND_PUBLIC, 32'd1);
    queue_request(KIND_PUBLIC, 32'hFFFF_FFFF);
    queue_request(KIND_PUBLIC, 32'd22);
    queue_request(KIND_PUBLIC, 32'd23);
    queue_request(KIND_SECRET, 32'd0);
    queue_request(KIND_SECRET, 32'd23);
    queue_request(KIND_SECRET, 32'hFFFF_FFFF);
    queue_request(KIND_SECRET, 32'd8);
    settle();

    // Largest 32-bit prime with an unreduced generator.
    write_reg(REG_MODULUS, 32'hFFFF_FFFB);
    write_reg(REG_GENERATOR, 32'hFFFF_FFFF);
    queue_request(KIND_PUBLIC, 32'h8000_0000);
    queue_request(KIND_PUBLIC, 32'hFFFF_FFFA);
    queue_request(KIND_SECRET, 32'hFFFF_FFFF);
    queue_request(KIND_SECRET, 32'hFFFF_FFFC);
    settle();

    write_reg(REG_MODULUS, 32'd1);
    queue_request(KIND_PUBLIC, 32'd5);
    queue_request(KIND_SECRET, 32'd7);
    settle();

    write_reg(REG_MODULUS, 32'd0);
    queue_request(KIND_PUBLIC, 32'd9);
    queue_request(KIND_SECRET, 32'd3);
    settle();

    write_reg(REG_MODULUS, 32'd2);
    write_reg(REG_GENERATOR, 32'd0);
    queue_request(KIND_PUBLIC, 32'd0);
    queue_request(KIND_PUBLIC, 32'd3);
    queue_request(KIND_SECRET, 32'd1);
    settle();

    write_reg(REG_MODULUS, 32'hFFFF_FFFF);
    write_reg(REG_GENERATOR, 32'hFFFF_FFFF);
    queue_request(KIND_PUBLIC, 32'h5555_5555);
    queue_request(KIND_SECRET, 32'hAAAA_AAAA);
    settle();

    // Random phases: mostly a key followed by a few peer keys, some loose items.
    for (phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 5))
        0: m = 32'hFFFF_FFFB;
        1: m = 32'd2147483647;
        2: m = $urandom_range(2, 1000);
        3: m = $urandom | 32'd1;
        4: m = 32'hFFFF_FFFF;
        default: m = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: g = 32'd2;
        1: g = 32'hFFFF_FFFF;
        2: g = $urandom_range(0, 50);
        default: g = $urandom;
      endcase
      write_reg(REG_MODULUS, m);
      write_reg(REG_GENERATOR, g);
      count = 0;
      while (count < 44) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_request(1'($urandom_range(0, 1)), pick_value());
          count++;
        end else begin
          queue_request(KIND_PUBLIC, pick_value());
          burst = $urandom_range(1, 5);
          count += burst + 1;
          repeat (burst) queue_request(KIND_SECRET, pick_value());
        end
      end
      settle();
    end

    repeat (2500) @(posedge clk);
    $display("Run covered %0d public-key and %0d shared-secret items, %0d of them before any key,",
             n_public, n_secret, n_missing);
    $display("across %0d register writes including moduli of 0, 1, 2 and all ones.", n_writes);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dhp_pkg.sv
rtl/dhp_if.sv
rtl/dhp_modmul.sv
rtl/diffie_hellman_party.sv
rtl/dhp_checker.sv
bench/tb_diffie_hellman_party.sv
